FILE: rtl/fsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the flow step adaptation block.
package fsa_pkg;

    localparam int SAMPLE_DEPTH = 64;
    localparam int CNT_W        = $clog2(SAMPLE_DEPTH + 1);

    localparam int TARGET_W = 7;
    localparam int STEP_W   = 8;
    localparam int COUNT_W  = 8;
    localparam int SAMPLE_W = 8;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Window around the target flow that counts as fine.
    localparam logic [SAMPLE_W:0] HIGH_MARGIN = 9'd7;
    localparam logic [TARGET_W-1:0] LOW_MARGIN = 7'd17;
    localparam logic [SAMPLE_W-1:0] LOW_FLOOR  = 8'd1;

    localparam logic [TARGET_W-1:0] TARGET_RST   = 7'd60;
    localparam logic [STEP_W-1:0]   MIN_STEP_RST = 8'd3;
    localparam logic [STEP_W-1:0]   MAX_STEP_RST = 8'd20;
    localparam logic [COUNT_W-1:0]  STOP_RST     = 8'd15;
    localparam logic [STEP_W-1:0]   STEP_RST     = 8'd3;

    typedef enum logic [1:0] {
        REG_TARGET_FLOW = 2'd0,
        REG_MIN_STEP    = 2'd1,
        REG_MAX_STEP    = 2'd2,
        REG_STOP_LIMIT  = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        CLASS_FINE = 2'd0,
        CLASS_LOW  = 2'd1,
        CLASS_HIGH = 2'd2
    } flow_class_t;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_END    = 1'b1
    } action_t;

endpackage

FILE: rtl/fsa_if.sv
`timescale 1ns / 1ps
// Handshake interfaces for the sample input and result output channels.
interface fsa_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] flow_sample;
    logic       peep_matched;

    modport source (output valid, output action, output flow_sample, output peep_matched,
                    input ready);
    modport sink   (input valid, input action, input flow_sample, input peep_matched,
                    output ready);
endinterface

interface fsa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] step_size;
    logic [1:0] flow_class;
    logic [7:0] oscillation_count;
    logic       tuning_frozen;

    modport source (output valid, output step_size, output flow_class,
                    output oscillation_count, output tuning_frozen, input ready);
    modport sink   (input valid, input step_size, input flow_class,
                    input oscillation_count, input tuning_frozen, output ready);
endinterface

FILE: rtl/flow_step_adaptation.sv
`timescale 1ns / 1ps
// Flow step adaptation: scans breath flow samples and tunes the blower DAC step.
// A beat accepted into the input register has its result loaded into the result register once that is free.
// Throughput: one beat per cycle while the result channel is not stalled; the input register and
// result register decouple the two channels, so a stalled result holds at most one further beat.
// Reset (rst_n, asynchronous): registers to their documented defaults, step 3, class fine.
module flow_step_adaptation (
    input  logic                         clk,
    input  logic                         rst_n,
    fsa_in_if.sink                       sample_in,
    fsa_out_if.source                    result_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fsa_pkg::PADDR_W-1:0]  paddr,
    input  logic [fsa_pkg::PDATA_W-1:0]  pwdata,
    output logic [fsa_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    // Configuration registers
    logic [fsa_pkg::TARGET_W-1:0] target_reg;
    logic [fsa_pkg::STEP_W-1:0]   min_step_reg;
    logic [fsa_pkg::STEP_W-1:0]   max_step_reg;
    logic [fsa_pkg::COUNT_W-1:0]  stop_limit_reg;
    fsa_pkg::reg_index_t          cfg_index;
    logic                         cfg_write;

    // Input stage
    logic                         in_valid_reg;
    logic                         in_action_reg;
    logic [fsa_pkg::SAMPLE_W-1:0] in_sample_reg;
    logic                         in_peep_reg;

    // Adaptation state
    logic [fsa_pkg::STEP_W-1:0]   step_reg, step_next;
    fsa_pkg::flow_class_t         stored_class_reg, stored_class_next;
    fsa_pkg::flow_class_t         scan_class_reg, scan_class_next;
    logic                         target_seen_reg, target_seen_next;
    logic [fsa_pkg::CNT_W-1:0]    samples_reg, samples_next;
    logic [fsa_pkg::COUNT_W-1:0]  flip_reg, flip_next;

    // Result stage
    logic                         out_valid_reg;
    logic [fsa_pkg::STEP_W-1:0]   out_step_reg;
    logic [1:0]                   out_class_reg;
    logic [fsa_pkg::COUNT_W-1:0]  out_count_reg;
    logic                         out_frozen_reg;

    logic                         out_load;
    logic                         fire;
    logic                         in_take;

    // Scan helpers
    logic [fsa_pkg::SAMPLE_W-1:0] low_bound;
    logic                         hit_target;
    logic                         above_high;
    logic                         below_low;
    logic                         tuning_allowed;

    assign pready    = 1'b1;
    assign cfg_index = fsa_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        case (cfg_index)
            fsa_pkg::REG_TARGET_FLOW: prdata = {{(fsa_pkg::PDATA_W-fsa_pkg::TARGET_W){1'b0}}, target_reg};
            fsa_pkg::REG_MIN_STEP:    prdata = {{(fsa_pkg::PDATA_W-fsa_pkg::STEP_W){1'b0}}, min_step_reg};
            fsa_pkg::REG_MAX_STEP:    prdata = {{(fsa_pkg::PDATA_W-fsa_pkg::STEP_W){1'b0}}, max_step_reg};
            fsa_pkg::REG_STOP_LIMIT:  prdata = {{(fsa_pkg::PDATA_W-fsa_pkg::COUNT_W){1'b0}}, stop_limit_reg};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= fsa_pkg::TARGET_RST;
            min_step_reg   <= fsa_pkg::MIN_STEP_RST;
            max_step_reg   <= fsa_pkg::MAX_STEP_RST;
            stop_limit_reg <= fsa_pkg::STOP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fsa_pkg::REG_TARGET_FLOW: target_reg     <= pwdata[fsa_pkg::TARGET_W-1:0];
                fsa_pkg::REG_MIN_STEP:    min_step_reg   <= pwdata[fsa_pkg::STEP_W-1:0];
                fsa_pkg::REG_MAX_STEP:    max_step_reg   <= pwdata[fsa_pkg::STEP_W-1:0];
                fsa_pkg::REG_STOP_LIMIT:  stop_limit_reg <= pwdata[fsa_pkg::COUNT_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Handshake: the result register loads when empty or being drained.
    assign out_load         = !out_valid_reg || result_out.ready;
    assign fire             = in_valid_reg && out_load;
    assign sample_in.ready  = !in_valid_reg || fire;
    assign in_take          = sample_in.valid && sample_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample_in.ready)
        begin
            in_valid_reg <= sample_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_action_reg <= sample_in.action;
            in_sample_reg <= sample_in.flow_sample;
            in_peep_reg   <= sample_in.peep_matched;
        end
    end

    // The low bound is max(target - 17, 1); targets of 18 or less give 1.
    always_comb
    begin
        if (target_reg > fsa_pkg::LOW_MARGIN + 7'd1)
        begin
            low_bound = {1'b0, target_reg - fsa_pkg::LOW_MARGIN};
        end
        else
        begin
            low_bound = fsa_pkg::LOW_FLOOR;
        end
    end

    assign hit_target     = (in_sample_reg == {1'b0, target_reg});
    assign above_high     = ({1'b0, in_sample_reg} > ({2'b00, target_reg} + fsa_pkg::HIGH_MARGIN));
    assign below_low      = (in_sample_reg < low_bound) && (in_sample_reg != '0);
    assign tuning_allowed = (flip_reg <= stop_limit_reg);

    always_comb
    begin
        step_next         = step_reg;
        stored_class_next = stored_class_reg;
        scan_class_next   = scan_class_reg;
        target_seen_next  = target_seen_reg;
        samples_next      = samples_reg;
        flip_next         = flip_reg;

        case (fsa_pkg::action_t'(in_action_reg))
            fsa_pkg::ACT_SAMPLE:
            begin
                if (samples_reg < fsa_pkg::CNT_W'(fsa_pkg::SAMPLE_DEPTH))
                begin
                    samples_next     = samples_reg + 1'b1;
                    target_seen_next = target_seen_reg || hit_target;
                    if (target_seen_next)
                    begin
                        if (above_high)
                        begin
                            scan_class_next = fsa_pkg::CLASS_HIGH;
                        end
                        else if (below_low)
                        begin
                            scan_class_next = fsa_pkg::CLASS_LOW;
                        end
                    end
                end
            end
            fsa_pkg::ACT_END:
            begin
                if (in_peep_reg)
                begin
                    if (tuning_allowed)
                    begin
                        // Each clamp acts only in its own direction.
                        if (stored_class_reg == fsa_pkg::CLASS_LOW)
                        begin
                            if (step_reg == '1)
                            begin
                                step_next = step_reg;
                            end
                            else
                            begin
                                step_next = step_reg + 1'b1;
                            end
                            if (step_next > max_step_reg)
                            begin
                                step_next = max_step_reg;
                            end
                        end
                        else if (stored_class_reg == fsa_pkg::CLASS_HIGH)
                        begin
                            if (step_reg == '0)
                            begin
                                step_next = step_reg;
                            end
                            else
                            begin
                                step_next = step_reg - 1'b1;
                            end
                            if (step_next < min_step_reg)
                            begin
                                step_next = min_step_reg;
                            end
                        end
                        if ((stored_class_reg != scan_class_reg) &&
                            (scan_class_reg != fsa_pkg::CLASS_FINE) &&
                            (stored_class_reg != fsa_pkg::CLASS_FINE) &&
                            (flip_reg != '1))
                        begin
                            flip_next = flip_reg + 1'b1;
                        end
                        stored_class_next = scan_class_reg;
                    end
                end
                else
                begin
                    stored_class_next = fsa_pkg::CLASS_FINE;
                end
                scan_class_next  = fsa_pkg::CLASS_FINE;
                target_seen_next = 1'b0;
                samples_next     = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= fsa_pkg::STEP_RST;
            stored_class_reg <= fsa_pkg::CLASS_FINE;
            scan_class_reg   <= fsa_pkg::CLASS_FINE;
            target_seen_reg  <= 1'b0;
            samples_reg      <= '0;
            flip_reg         <= '0;
        end
        else if (fire)
        begin
            step_reg         <= step_next;
            stored_class_reg <= stored_class_next;
            scan_class_reg   <= scan_class_next;
            target_seen_reg  <= target_seen_next;
            samples_reg      <= samples_next;
            flip_reg         <= flip_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_step_reg   <= step_next;
            out_class_reg  <= stored_class_next;
            out_count_reg  <= flip_next;
            out_frozen_reg <= (flip_next > stop_limit_reg);
        end
    end

    assign result_out.valid             = out_valid_reg;
    assign result_out.step_size         = out_step_reg;
    assign result_out.flow_class        = out_class_reg;
    assign result_out.oscillation_count = out_count_reg;
    assign result_out.tuning_frozen     = out_frozen_reg;

endmodule

FILE: verif/tb_flow_step_adaptation.sv
`timescale 1ns / 1ps
// Testbench for flow_step_adaptation: breath streams checked beat by beat against a predictor.
module tb_flow_step_adaptation;

    typedef struct {
        logic [fsa_pkg::STEP_W-1:0]  step;
        fsa_pkg::flow_class_t        cls;
        logic [fsa_pkg::COUNT_W-1:0] flips;
        logic                        frozen;
    } breath_result_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } stall_mode_t;

    localparam int MAX_REPORTS    = 10;
    localparam int SINGLE_GAP_PCT = 56;
    localparam int BOTH_GAP_PCT   = 37;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [fsa_pkg::PADDR_W-1:0] paddr;
    logic [fsa_pkg::PDATA_W-1:0] pwdata;
    logic [fsa_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    fsa_in_if  sample_ch ();
    fsa_out_if result_ch ();

    flow_step_adaptation dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_ch),
        .result_out (result_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Mirror of the configuration registers.
    logic [fsa_pkg::TARGET_W-1:0] cfg_target;
    logic [fsa_pkg::STEP_W-1:0]   cfg_min_step;
    logic [fsa_pkg::STEP_W-1:0]   cfg_max_step;
    logic [fsa_pkg::COUNT_W-1:0]  cfg_stop;

    // Predicted state of the tuner.
    logic [fsa_pkg::STEP_W-1:0]   p_step;
    fsa_pkg::flow_class_t         p_stored;
    fsa_pkg::flow_class_t         p_scan;
    logic                         p_armed;
    int                           p_samples;
    logic [fsa_pkg::COUNT_W-1:0]  p_flips;

    breath_result_t expected_results[$];
    int n_errors;
    int beats_sent;
    int sender_gap_pct;
    int receiver_stall_pct;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
        begin
            $display("mismatch: %s", msg);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        breath_result_t want_r;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                note_error("result beat arrived with nothing predicted");
            end
            else
            begin
                want_r = expected_results.pop_front();
                if (result_ch.step_size !== want_r.step ||
                    result_ch.flow_class !== want_r.cls ||
                    result_ch.oscillation_count !== want_r.flips ||
                    result_ch.tuning_frozen !== want_r.frozen)
                begin
                    note_error($sformatf(
                        "step %0d/%0d class %0d/%0d count %0d/%0d frozen %0d/%0d (exp/got)",
                        want_r.step, result_ch.step_size, want_r.cls, result_ch.flow_class,
                        want_r.flips, result_ch.oscillation_count,
                        want_r.frozen, result_ch.tuning_frozen));
                end
            end
        end
    end

    // Lower edge of the fine window: target minus the margin, never below the floor.
    function automatic int low_bound();
        int lo;
        lo = int'(cfg_target) - int'(fsa_pkg::LOW_MARGIN);
        if (lo <= int'(fsa_pkg::LOW_FLOOR))
        begin
            lo = int'(fsa_pkg::LOW_FLOOR);
        end
        return lo;
    endfunction

    function automatic breath_result_t predict_beat(fsa_pkg::action_t act,
                                                    logic [fsa_pkg::SAMPLE_W-1:0] s,
                                                    logic peep);
        breath_result_t       r;
        int                   tgt;
        int                   lo;
        int                   v;
        fsa_pkg::flow_class_t prev;
        tgt = int'(cfg_target);
        lo  = low_bound();
        v   = int'(s);
        if (act == fsa_pkg::ACT_SAMPLE)
        begin
            if (p_samples < fsa_pkg::SAMPLE_DEPTH)
            begin
                if (v == tgt)
                begin
                    p_armed = 1'b1;
                end
                if (p_armed)
                begin
                    if (v > tgt + int'(fsa_pkg::HIGH_MARGIN))
                    begin
                        p_scan = fsa_pkg::CLASS_HIGH;
                    end
                    else if (v < lo && v != 0)
                    begin
                        p_scan = fsa_pkg::CLASS_LOW;
                    end
                end
                p_samples++;
            end
        end
        else
        begin
            if (peep)
            begin
                if (p_flips <= cfg_stop)
                begin
                    prev = p_stored;
                    if (prev == fsa_pkg::CLASS_LOW)
                    begin
                        if (p_step != {fsa_pkg::STEP_W{1'b1}})
                        begin
                            p_step++;
                        end
                        if (p_step > cfg_max_step)
                        begin
                            p_step = cfg_max_step;
                        end
                    end
                    else if (prev == fsa_pkg::CLASS_HIGH)
                    begin
                        if (p_step != '0)
                        begin
                            p_step--;
                        end
                        if (p_step < cfg_min_step)
                        begin
                            p_step = cfg_min_step;
                        end
                    end
                    if (prev != p_scan && p_scan != fsa_pkg::CLASS_FINE &&
                        prev != fsa_pkg::CLASS_FINE &&
                        p_flips != {fsa_pkg::COUNT_W{1'b1}})
                    begin
                        p_flips++;
                    end
                    p_stored = p_scan;
                end
            end
            else
            begin
                p_stored = fsa_pkg::CLASS_FINE;
            end
            p_scan    = fsa_pkg::CLASS_FINE;
            p_armed   = 1'b0;
            p_samples = 0;
        end
        r.step   = p_step;
        r.cls    = p_stored;
        r.flips  = p_flips;
        r.frozen = (p_flips > cfg_stop);
        return r;
    endfunction

    task automatic set_stall_mode(stall_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                sender_gap_pct     = SINGLE_GAP_PCT;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                sender_gap_pct     = 0;
                receiver_stall_pct = SINGLE_GAP_PCT;
            end
            IDLE_BOTH:
            begin
                sender_gap_pct     = BOTH_GAP_PCT;
                receiver_stall_pct = BOTH_GAP_PCT;
            end
            default:
            begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 0;
            end
        endcase
    endtask

    // Presents one beat, holding it until accepted; valid stays high for a following beat.
    task automatic send_beat(fsa_pkg::action_t act, logic [fsa_pkg::SAMPLE_W-1:0] s,
                             logic peep);
        if (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct)
        begin
            sample_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_gap_pct);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.action       <= act;
        sample_ch.flow_sample  <= s;
        sample_ch.peep_matched <= peep;
        do @(posedge clk); while (!sample_ch.ready);
        expected_results.push_back(predict_beat(act, s, peep));
        beats_sent++;
    endtask

    task automatic send_sample(int s);
        send_beat(fsa_pkg::ACT_SAMPLE, fsa_pkg::SAMPLE_W'(s), 1'($urandom_range(1)));
    endtask

    task automatic send_end(logic peep);
        send_beat(fsa_pkg::ACT_END, fsa_pkg::SAMPLE_W'($urandom_range(255)), peep);
    endtask

    // Stops sending and waits until every predicted result has been seen.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    // Writes a register once the block is idle, then reads it back.
    task automatic write_reg(fsa_pkg::reg_index_t idx, int value);
        logic [fsa_pkg::PDATA_W-1:0] mask;
        logic [fsa_pkg::PDATA_W-1:0] data;
        logic [fsa_pkg::PDATA_W-1:0] readback;
        drain();
        mask = (idx == fsa_pkg::REG_TARGET_FLOW) ?
               fsa_pkg::PDATA_W'({fsa_pkg::TARGET_W{1'b1}}) :
               fsa_pkg::PDATA_W'({fsa_pkg::STEP_W{1'b1}});
        data = ($urandom() & ~mask) | (fsa_pkg::PDATA_W'(value) & mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= fsa_pkg::PADDR_W'(int'(idx) * 4);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // Back-to-back read of the same register.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            fsa_pkg::REG_TARGET_FLOW: cfg_target   = data[fsa_pkg::TARGET_W-1:0];
            fsa_pkg::REG_MIN_STEP:    cfg_min_step = data[fsa_pkg::STEP_W-1:0];
            fsa_pkg::REG_MAX_STEP:    cfg_max_step = data[fsa_pkg::STEP_W-1:0];
            fsa_pkg::REG_STOP_LIMIT:  cfg_stop     = data[fsa_pkg::COUNT_W-1:0];
            default:                  ;
        endcase
        if ((readback & mask) !== (data & mask))
        begin
            note_error($sformatf("register %0d read %0h, wrote %0h", idx, readback & mask,
                                 data & mask));
        end
        @(posedge clk);
    endtask

    // A breath that arms on the target and then lands in the wanted class.
    task automatic send_classed_breath(fsa_pkg::flow_class_t want, logic peep);
        int tgt;
        int lo;
        tgt = int'(cfg_target);
        lo  = low_bound();
        send_sample(tgt);
        repeat ($urandom_range(2))
            send_sample($urandom_range(tgt + int'(fsa_pkg::HIGH_MARGIN), lo));
        if (want == fsa_pkg::CLASS_LOW)
        begin
            send_sample($urandom_range(lo - 1, 1));
        end
        else if (want == fsa_pkg::CLASS_HIGH)
        begin
            send_sample($urandom_range(255, tgt + int'(fsa_pkg::HIGH_MARGIN) + 1));
        end
        send_end(peep);
    endtask

    // Samples weighted towards the target, both sides of the window and its edges.
    function automatic int pick_sample();
        int t;
        int lo;
        int v;
        t  = int'(cfg_target);
        lo = low_bound();
        case ($urandom_range(9))
            0, 1: v = t;
            2, 3: v = $urandom_range(255, t + int'(fsa_pkg::HIGH_MARGIN) + 1);
            4, 5: v = (lo > int'(fsa_pkg::LOW_FLOOR)) ? int'($urandom_range(lo - 1, 1)) : t;
            6:    v = 0;
            7:
            begin
                case ($urandom_range(3))
                    0:       v = t + int'(fsa_pkg::HIGH_MARGIN);
                    1:       v = t + int'(fsa_pkg::HIGH_MARGIN) + 1;
                    2:       v = lo;
                    default: v = lo - 1;
                endcase
            end
            default: v = $urandom_range(255);
        endcase
        return v;
    endfunction

    task automatic send_random_breath();
        int len;
        len = ($urandom_range(99) < 8) ? $urandom_range(80, 60) : $urandom_range(8, 1);
        repeat (len) send_sample(pick_sample());
        send_end($urandom_range(99) < 85);
    endtask

    task automatic test_reset_defaults();
        set_stall_mode(IDLE_NONE);
        send_sample(60);
        send_sample(30);
        send_end(1'b1);
        send_sample(60);
        send_sample(70);
        send_end(1'b1);
        send_end(1'b1);
        send_end(1'b0);
    endtask

    task automatic test_directed_cases();
        set_stall_mode(IDLE_NONE);
        // With a zero target a zero sample arms, yet zero samples never class.
        write_reg(fsa_pkg::REG_TARGET_FLOW, 0);
        send_sample(5);
        send_sample(0);
        send_sample(0);
        send_sample(8);
        send_end(1'b1);
        send_sample(0);
        send_sample(255);
        send_end(1'b0);
        // Top target: the window edges sit exactly on the thresholds.
        write_reg(fsa_pkg::REG_TARGET_FLOW, 127);
        send_sample(134);
        send_sample(127);
        send_sample(134);
        send_sample(135);
        send_sample(110);
        send_sample(109);
        send_sample(1);
        send_end(1'b1);
        send_sample(127);
        send_sample(0);
        send_end(1'b1);
        // A small target leaves no room below the floor, so nothing reads as low.
        write_reg(fsa_pkg::REG_TARGET_FLOW, 10);
        send_sample(10);
        send_sample(0);
        send_sample(1);
        send_end(1'b1);
    endtask

    task automatic test_sample_depth();
        set_stall_mode(IDLE_NONE);
        write_reg(fsa_pkg::REG_TARGET_FLOW, 60);
        // Arms on the last counted sample; the high one after it is beyond the depth.
        repeat (fsa_pkg::SAMPLE_DEPTH - 1) send_sample(0);
        send_sample(60);
        send_sample(200);
        send_end(1'b1);
        // High on the last counted sample; later low samples must not win.
        send_sample(60);
        repeat (fsa_pkg::SAMPLE_DEPTH - 2) send_sample(60);
        send_sample(200);
        repeat (6) send_sample(20);
        send_end(1'b1);
    endtask

    task automatic test_step_clamps();
        set_stall_mode(IDLE_RECEIVER);
        write_reg(fsa_pkg::REG_TARGET_FLOW, 60);
        write_reg(fsa_pkg::REG_STOP_LIMIT, 255);
        write_reg(fsa_pkg::REG_MIN_STEP, 255);
        write_reg(fsa_pkg::REG_MAX_STEP, 255);
        send_classed_breath(fsa_pkg::CLASS_HIGH, 1'b1);
        send_classed_breath(fsa_pkg::CLASS_FINE, 1'b1);
        write_reg(fsa_pkg::REG_MIN_STEP, 0);
        // Raising from the top saturates.
        repeat (3) send_classed_breath(fsa_pkg::CLASS_LOW, 1'b1);
        write_reg(fsa_pkg::REG_MAX_STEP, 0);
        send_classed_breath(fsa_pkg::CLASS_HIGH, 1'b1);
        send_classed_breath(fsa_pkg::CLASS_FINE, 1'b1);
        // Crossed limits: each clamp acts on its own direction only.
        write_reg(fsa_pkg::REG_MIN_STEP, 50);
        write_reg(fsa_pkg::REG_MAX_STEP, 10);
        send_classed_breath(fsa_pkg::CLASS_LOW, 1'b1);
        send_classed_breath(fsa_pkg::CLASS_HIGH, 1'b1);
        send_classed_breath(fsa_pkg::CLASS_FINE, 1'b1);
    endtask

    task automatic test_freeze();
        set_stall_mode(IDLE_SENDER);
        write_reg(fsa_pkg::REG_TARGET_FLOW, 40);
        write_reg(fsa_pkg::REG_MIN_STEP, 2);
        write_reg(fsa_pkg::REG_MAX_STEP, 30);
        write_reg(fsa_pkg::REG_STOP_LIMIT, int'(p_flips));
        send_classed_breath(fsa_pkg::CLASS_FINE, 1'b0);
        send_classed_breath(fsa_pkg::CLASS_LOW, 1'b1);
        send_classed_breath(fsa_pkg::CLASS_HIGH, 1'b1);
        // Frozen now: matched breaths must hold everything, unmatched ones still clear the class.
        send_classed_breath(fsa_pkg::CLASS_LOW, 1'b1);
        send_classed_breath(fsa_pkg::CLASS_HIGH, 1'b1);
        send_end(1'b0);
        write_reg(fsa_pkg::REG_STOP_LIMIT, 255);
        send_classed_breath(fsa_pkg::CLASS_LOW, 1'b1);
        send_classed_breath(fsa_pkg::CLASS_HIGH, 1'b1);
    endtask

    task automatic test_random_breaths(stall_mode_t mode, int n_beats, bit pause_midway,
                                       int target, int min_s, int max_s);
        int first;
        int r;
        bit paused;
        write_reg(fsa_pkg::REG_TARGET_FLOW, target);
        write_reg(fsa_pkg::REG_MIN_STEP, min_s);
        write_reg(fsa_pkg::REG_MAX_STEP, max_s);
        write_reg(fsa_pkg::REG_STOP_LIMIT,
                  (p_flips < 254) ? int'($urandom_range(254, p_flips)) : 254);
        set_stall_mode(mode);
        first  = beats_sent;
        paused = 1'b0;
        while (beats_sent - first < n_beats)
        begin
            if (pause_midway && !paused && beats_sent - first >= n_beats / 2)
            begin
                drain();
                paused = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 85)
            begin
                send_random_breath();
            end
            else if (r < 93)
            begin
                send_end(1'($urandom_range(1)));
            end
            else
            begin
                repeat ($urandom_range(3, 1)) send_sample($urandom_range(255));
            end
        end
    endtask

    task automatic test_flip_saturation();
        fsa_pkg::flow_class_t want;
        int                   extra;
        write_reg(fsa_pkg::REG_TARGET_FLOW, $urandom_range(120, 30));
        write_reg(fsa_pkg::REG_MIN_STEP, 0);
        write_reg(fsa_pkg::REG_MAX_STEP, 255);
        write_reg(fsa_pkg::REG_STOP_LIMIT, 255);
        set_stall_mode(IDLE_BOTH);
        want  = fsa_pkg::CLASS_LOW;
        extra = 0;
        // Alternate classes until the count has sat at its top for a while.
        while (extra < 8)
        begin
            send_classed_breath(want, $urandom_range(99) >= 3);
            want = (want == fsa_pkg::CLASS_LOW) ? fsa_pkg::CLASS_HIGH : fsa_pkg::CLASS_LOW;
            if (p_flips == {fsa_pkg::COUNT_W{1'b1}})
            begin
                extra++;
            end
        end
        write_reg(fsa_pkg::REG_STOP_LIMIT, 254);
        send_classed_breath(fsa_pkg::CLASS_LOW, 1'b1);
        send_classed_breath(fsa_pkg::CLASS_HIGH, 1'b1);
        write_reg(fsa_pkg::REG_STOP_LIMIT, 255);
        send_classed_breath(fsa_pkg::CLASS_LOW, 1'b1);
        send_classed_breath(fsa_pkg::CLASS_HIGH, 1'b1);
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.action       = fsa_pkg::ACT_SAMPLE;
        sample_ch.flow_sample  = '0;
        sample_ch.peep_matched = 1'b0;
        cfg_target             = fsa_pkg::TARGET_RST;
        cfg_min_step           = fsa_pkg::MIN_STEP_RST;
        cfg_max_step           = fsa_pkg::MAX_STEP_RST;
        cfg_stop               = fsa_pkg::STOP_RST;
        p_step                 = fsa_pkg::STEP_RST;
        p_stored               = fsa_pkg::CLASS_FINE;
        p_scan                 = fsa_pkg::CLASS_FINE;
        p_armed                = 1'b0;
        p_samples              = 0;
        p_flips                = '0;
        n_errors               = 0;
        beats_sent             = 0;
        set_stall_mode(IDLE_NONE);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_cases();
        test_sample_depth();
        test_step_clamps();
        test_freeze();
        test_random_breaths(IDLE_NONE, 70, 1'b0, 120, 0, 255);
        test_random_breaths(IDLE_SENDER, 70, 1'b1, $urandom_range(119, 2), $urandom_range(10),
                            $urandom_range(255, 200));
        test_random_breaths(IDLE_RECEIVER, 70, 1'b0, 1, 255, 0);
        test_random_breaths(IDLE_BOTH, 70, 1'b0, $urandom_range(120, 1), $urandom_range(255),
                            $urandom_range(255));
        test_flip_saturation();

        drain();
        if (n_errors == 0 && expected_results.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: flow_step_adaptation.f
rtl/fsa_pkg.sv
rtl/fsa_if.sv
rtl/flow_step_adaptation.sv
verif/tb_flow_step_adaptation.sv
